// ===== src/key_set_change_events_top_assert.svh =====
// Assertion helpers used by the RTL of the key set change event block.
// All checks are sampled on the rising edge of clk_i and are off while rst_ni is low.
`ifndef KEY_SET_CHANGE_EVENTS_TOP_ASSERT_SVH
`define KEY_SET_CHANGE_EVENTS_TOP_ASSERT_SVH

// Property that must hold on every clock edge out of reset.
`define KSCEV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen on a clock edge out of reset.
`define KSCEV_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== src/kscev_pkg.sv =====
`default_nettype none

package kscev_pkg;

  // Number of keycode slots on the input. There are always eight slot fields,
  // but only the first SLOTS of them take part.
  localparam int SLOT_MAX = 8;
  localparam int SLOTS    = 8;
  localparam int CODE_W   = 8;

  // One candidate event per old slot (release) and per new slot (press).
  localparam int EVENTS   = 2 * SLOTS;

  typedef logic [CODE_W-1:0] code_t;
  typedef code_t [SLOT_MAX-1:0] slot_set_t;

  // Result of comparing one tick's set with the previous one. The lower
  // SLOTS entries are releases of old codes, the upper SLOTS are presses.
  typedef struct packed {
    logic [EVENTS-1:0]         mask;
    code_t [EVENTS-1:0]        code;
  } diff_t;

endpackage

`default_nettype wire

// ===== src/kscev_in_if.sv =====
`default_nettype none

interface kscev_in_if;
  import kscev_pkg::*;

  logic  valid;
  logic  ready;
  code_t slot0_code;
  code_t slot1_code;
  code_t slot2_code;
  code_t slot3_code;
  code_t slot4_code;
  code_t slot5_code;
  code_t slot6_code;
  code_t slot7_code;

  modport source (
    output valid, slot0_code, slot1_code, slot2_code, slot3_code,
           slot4_code, slot5_code, slot6_code, slot7_code,
    input  ready
  );

  modport sink (
    input  valid, slot0_code, slot1_code, slot2_code, slot3_code,
           slot4_code, slot5_code, slot6_code, slot7_code,
    output ready
  );

endinterface

`default_nettype wire

// ===== src/kscev_out_if.sv =====
`default_nettype none

interface kscev_out_if;
  import kscev_pkg::*;

  logic  valid;
  logic  ready;
  logic  has_event;
  logic  is_press;
  code_t event_code;
  logic  tick_done;

  modport source (
    output valid, has_event, is_press, event_code, tick_done,
    input  ready
  );

  modport sink (
    input  valid, has_event, is_press, event_code, tick_done,
    output ready
  );

endinterface

`default_nettype wire

// ===== src/kscev_diff.sv =====
`default_nettype none

module kscev_diff (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  kscev_pkg::slot_set_t  now_i,
  input  logic                  take_i,
  output kscev_pkg::diff_t      diff_o
);
  import kscev_pkg::*;

  slot_set_t prior_q;
  slot_set_t prior_d;
  slot_set_t now_m;

  // Slots past SLOTS count as empty.
  always_comb begin
    for (int i = 0; i < SLOT_MAX; i++) begin
      now_m[i] = (i < SLOTS) ? now_i[i] : '0;
    end
  end

  // A release for every old key missing from the new set, a press for every
  // new key missing from the old set. Each slot is judged on its own, so a
  // repeated code yields one event per slot that holds it.
  always_comb begin
    logic hit_old;
    logic hit_new;
    diff_o = '0;
    for (int i = 0; i < SLOTS; i++) begin
      hit_old = 1'b0;
      hit_new = 1'b0;
      for (int j = 0; j < SLOTS; j++) begin
        hit_old = hit_old | (now_m[j] == prior_q[i]);
        hit_new = hit_new | (prior_q[j] == now_m[i]);
      end
      diff_o.mask[i]         = (prior_q[i] != '0) && !hit_old;
      diff_o.code[i]         = prior_q[i];
      diff_o.mask[SLOTS + i] = (now_m[i] != '0) && !hit_new;
      diff_o.code[SLOTS + i] = now_m[i];
    end
  end

  assign prior_d = take_i ? now_m : prior_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_q <= '0;
    end else begin
      prior_q <= prior_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/kscev_emit.sv =====
`default_nettype none

`include "key_set_change_events_top_assert.svh"

module kscev_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kscev_pkg::diff_t  diff_i,
  input  logic              take_i,
  output logic              free_o,
  kscev_out_if.source       out_o
);
  import kscev_pkg::*;

  // Pending events of the tick in progress.
  logic [EVENTS-1:0]  mask_q, mask_d;
  code_t [EVENTS-1:0] code_q, code_d;
  logic               none_q, none_d;

  // Output register.
  logic               ovld_q, ovld_d;
  logic               has_q, has_d;
  logic               prs_q, prs_d;
  code_t              ecode_q, ecode_d;
  logic               done_q, done_d;

  logic               busy;
  logic               adv;
  logic [EVENTS-1:0]  first;
  logic [EVENTS-1:0]  rest;
  code_t              sel_code;

  assign busy  = (|mask_q) || none_q;
  assign adv   = !ovld_q || out_o.ready;
  assign first = mask_q & (~mask_q + 1'b1);
  assign rest  = mask_q & ~first;

  always_comb begin
    sel_code = '0;
    for (int i = 0; i < EVENTS; i++) begin
      sel_code = sel_code | (first[i] ? code_q[i] : '0);
    end
  end

  // A new tick may enter once the last result of the current one moves
  // into the output register.
  assign free_o = !busy || (adv && (none_q || (rest == '0)));

  always_comb begin
    mask_d  = mask_q;
    code_d  = code_q;
    none_d  = none_q;
    ovld_d  = ovld_q;
    has_d   = has_q;
    prs_d   = prs_q;
    ecode_d = ecode_q;
    done_d  = done_q;
    if (adv) begin
      ovld_d = busy;
      if (busy) begin
        if (none_q) begin
          has_d   = 1'b0;
          prs_d   = 1'b0;
          ecode_d = '0;
          done_d  = 1'b1;
        end else begin
          has_d   = 1'b1;
          prs_d   = |first[EVENTS-1:SLOTS];
          ecode_d = sel_code;
          done_d  = (rest == '0);
        end
        mask_d = rest;
        none_d = 1'b0;
      end
    end
    if (take_i) begin
      mask_d = diff_i.mask;
      code_d = diff_i.code;
      none_d = (diff_i.mask == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      none_q <= 1'b0;
      ovld_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      none_q <= none_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q  <= code_d;
    has_q   <= has_d;
    prs_q   <= prs_d;
    ecode_q <= ecode_d;
    done_q  <= done_d;
  end

  assign out_o.valid      = ovld_q;
  assign out_o.has_event  = has_q;
  assign out_o.is_press   = prs_q;
  assign out_o.event_code = ecode_q;
  assign out_o.tick_done  = done_q;

  `KSCEV_ASSERT(a_take_loads, take_i |=> busy, "accepted tick left nothing pending")
  `KSCEV_NEVER(a_none_and_mask, none_q && (|mask_q), "marker pending beside events")
  `KSCEV_ASSERT(a_mid_is_event, (ovld_q && !done_q) |-> has_q, "marker not last of tick")
  `KSCEV_ASSERT(a_marker_clean, (ovld_q && !has_q) |-> (done_q && !prs_q && ecode_q == '0),
                "malformed no-event marker")

endmodule

`default_nettype wire

// ===== src/key_set_change_events_top.sv =====
// Channel | Direction | Payload
// in_i    | sink      | slot0_code .. slot7_code, 8 bits each, 0 is an empty slot
// out_o   | source    | has_event, is_press, event_code[7:0], tick_done
//
// A tick is taken and compared at once with the previous tick's set. Its first result
// goes via the pending event mask into the output register; a tick gives 1 to 16 results,
// one per cycle unless out_o stalls, paced by the single output register draining the mask.
// The next tick is taken in the same cycle the last result of the current one is loaded.
// Reset clears the previous set to all empty and drops any pending results.
// A stall on out_o holds the output register and the pending events in place.
`default_nettype none

module key_set_change_events_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  kscev_in_if.sink    in_i,
  kscev_out_if.source out_o
);
  import kscev_pkg::*;

  // Gather the slot fields into one array for the comparison logic.
  slot_set_t now_set;
  diff_t     diff;
  logic      free;
  logic      take;

  assign now_set[0] = in_i.slot0_code;
  assign now_set[1] = in_i.slot1_code;
  assign now_set[2] = in_i.slot2_code;
  assign now_set[3] = in_i.slot3_code;
  assign now_set[4] = in_i.slot4_code;
  assign now_set[5] = in_i.slot5_code;
  assign now_set[6] = in_i.slot6_code;
  assign now_set[7] = in_i.slot7_code;

  // The input is ready whenever the event queue can take a new tick, so a
  // tick is never held back by an idle output.
  assign in_i.ready = free;
  assign take       = in_i.valid && free;

  // Comparison against the stored previous set; the set is replaced on each
  // accepted transfer.
  kscev_diff u_diff (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .now_i  (now_set),
    .take_i (take),
    .diff_o (diff)
  );

  // Pending events are sent in order: releases by slot, then presses by slot,
  // or a single no-event marker when nothing changed.
  kscev_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .diff_i (diff),
    .take_i (take),
    .free_o (free),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire
